[hdl/dsi_rru_pkg.sv]
// ----------------------------------------------------------------------------
// dsi_rru_pkg
// Types and codes shared by the read response unpacker.
// ----------------------------------------------------------------------------
package dsi_rru_pkg;

  // input item kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  // result outcome codes
  localparam logic [2:0] OUT_BYTE     = 3'd0;
  localparam logic [2:0] OUT_SIZE     = 3'd1;
  localparam logic [2:0] OUT_ERRREP   = 3'd2;
  localparam logic [2:0] OUT_UNKNOWN  = 3'd3;
  localparam logic [2:0] OUT_UNDERRUN = 3'd4;
  localparam logic [2:0] OUT_BADLEN   = 3'd5;

  // response data types
  localparam logic [7:0] DT_SHORT1_A  = 8'h11;
  localparam logic [7:0] DT_SHORT1_B  = 8'h21;
  localparam logic [7:0] DT_SHORT2_A  = 8'h12;
  localparam logic [7:0] DT_SHORT2_B  = 8'h22;
  localparam logic [7:0] DT_LONG_A    = 8'h1a;
  localparam logic [7:0] DT_LONG_B    = 8'h1c;
  localparam logic [7:0] DT_ACK_ERR   = 8'h02;

  // most results one item can cause
  localparam int unsigned MaxResults  = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] rx_word;
    logic [15:0] expected_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [2:0]  outcome;
    logic [15:0] error_report;
    logic        last;
  } out_item_t;

endpackage

[hdl/dsi_read_response_unpacker_top.sv]
// ----------------------------------------------------------------------------
// dsi_read_response_unpacker_top
// Decodes read responses from a display serial link receive queue into bytes
// and status results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one receive queue
//   event per transfer: a header word with the requested byte count, a
//   payload word, or a queue-empty mark. Output channel (out_valid /
//   out_stall / out_data) gives one result per transfer: a payload byte or
//   a status, with last set on the final result of a response.
//   An accepted item is decoded in one pass into a four-entry result buffer;
//   its results then move from the buffer to the output register. Results
//   leave the buffer one per cycle while the receiver does not stall; a
//   header gives at most two results and a payload word at most four. The
//   next item is taken while the last result of the previous one is still
//   moving to the output register.
//   Reset (rst_n low, synchronous) empties the buffer and the output register
//   and returns the decoder to idle. When the receiver stalls, the output
//   register holds, the buffer stops draining and in_stall rises once the
//   buffer cannot take another item.
// ----------------------------------------------------------------------------
module dsi_read_response_unpacker_top
  import dsi_rru_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // decoder state
  logic        collecting_r, collecting_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;

  // result buffer
  out_item_t   res_r [MaxResults];
  out_item_t   res_nxt [MaxResults];
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  idx_r;
  logic [2:0]  pending;

  // output register
  logic        out_valid_r;
  out_item_t   out_r;

  logic        take;
  logic        out_load;
  logic        in_xfer;

  // handshake control
  assign pending  = cnt_r - idx_r;
  assign take     = out_valid_r & ~out_stall;
  assign out_load = (pending != 3'd0) && (!out_valid_r || take);
  assign in_stall = !((pending == 3'd0) || ((pending == 3'd1) && out_load));
  assign in_xfer  = in_valid & ~in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // single-pass decode of one input item
  always_comb begin
    logic [7:0]  dtype;
    logic [15:0] hfield;
    logic [15:0] want;
    logic [2:0]  n;
    dtype          = in_data.rx_word[7:0];
    hfield         = in_data.rx_word[23:8];
    want           = in_data.expected_count;
    n              = 3'd0;
    collecting_nxt = collecting_r;
    bytes_left_nxt = bytes_left_r;
    for (int k = 0; k < MaxResults; k++) begin
      res_nxt[k].data_byte    = 8'd0;
      res_nxt[k].outcome      = OUT_BYTE;
      res_nxt[k].error_report = 16'd0;
      res_nxt[k].last         = 1'b1;
    end
    case (in_data.kind)
      KIND_HEADER: begin
        collecting_nxt = 1'b0;
        bytes_left_nxt = 16'd0;
        n              = 3'd1;
        if (want == 16'd0) begin
          res_nxt[0].outcome = OUT_BADLEN;
        end else if (dtype inside {DT_SHORT1_A, DT_SHORT1_B}) begin
          if (want != 16'd1) begin
            res_nxt[0].outcome = OUT_SIZE;
          end else begin
            res_nxt[0].data_byte = in_data.rx_word[15:8];
          end
        end else if (dtype inside {DT_SHORT2_A, DT_SHORT2_B}) begin
          if (want != 16'd2) begin
            res_nxt[0].outcome = OUT_SIZE;
          end else begin
            n                    = 3'd2;
            res_nxt[0].data_byte = in_data.rx_word[15:8];
            res_nxt[0].last      = 1'b0;
            res_nxt[1].data_byte = in_data.rx_word[23:16];
          end
        end else if (dtype inside {DT_LONG_A, DT_LONG_B}) begin
          if (hfield != want) begin
            res_nxt[0].outcome = OUT_SIZE;
          end else begin
            n              = 3'd0;
            collecting_nxt = 1'b1;
            bytes_left_nxt = want;
          end
        end else if (dtype == DT_ACK_ERR) begin
          res_nxt[0].outcome      = OUT_ERRREP;
          res_nxt[0].error_report = hfield;
        end else begin
          res_nxt[0].outcome = OUT_UNKNOWN;
        end
      end
      KIND_PAYLOAD: begin
        if (collecting_r) begin
          // up to four bytes, little-endian
          n = (bytes_left_r >= 16'(MaxResults)) ? 3'(MaxResults) : bytes_left_r[2:0];
          for (int k = 0; k < MaxResults; k++) begin
            res_nxt[k].data_byte = in_data.rx_word[8*k +: 8];
            res_nxt[k].last      = (bytes_left_r == 16'(k + 1));
          end
          bytes_left_nxt = bytes_left_r - {13'd0, n};
          collecting_nxt = (bytes_left_r != {13'd0, n});
        end
      end
      KIND_EMPTY: begin
        if (collecting_r) begin
          collecting_nxt     = 1'b0;
          bytes_left_nxt     = 16'd0;
          n                  = 3'd1;
          res_nxt[0].outcome = OUT_UNDERRUN;
        end
      end
      default: begin
        n = 3'd0;
      end
    endcase
    cnt_nxt = n;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      bytes_left_r <= 16'd0;
      cnt_r        <= 3'd0;
      idx_r        <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        collecting_r <= collecting_nxt;
        bytes_left_r <= bytes_left_nxt;
        cnt_r        <= cnt_nxt;
        idx_r        <= 3'd0;
      end else if (out_load) begin
        idx_r <= idx_r + 3'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int k = 0; k < MaxResults; k++) begin
        res_r[k] <= res_nxt[k];
      end
    end
    if (out_load) begin
      out_r <= res_r[idx_r[1:0]];
    end
  end

`ifndef NO_ASSERTIONS
  // buffer read pointer never passes the fill count
  a_idx_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r <= cnt_r) && (cnt_r <= 3'(MaxResults)))
    else $error("result buffer pointer out of range");

  // collecting exactly while bytes are owed
  a_collect_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    collecting_r == (bytes_left_r != 16'd0))
    else $error("collecting flag disagrees with byte count");

  // zero request length gives one bad-length status
  a_badlen: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.kind == KIND_HEADER) && (in_data.expected_count == 16'd0))
    |=> (cnt_r == 3'd1) && (res_r[0].outcome == OUT_BADLEN) && !collecting_r)
    else $error("zero request length not reported");

  // status results always close a response
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.outcome != OUT_BYTE)) |-> out_r.last)
    else $error("status result without last");
`endif

endmodule
